/* src/polygon_plane_clipper_defines.svh */
// Assertion macros used by the clipper top level.
`ifndef POLYGON_PLANE_CLIPPER_DEFINES_SVH
`define POLYGON_PLANE_CLIPPER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define PPC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define PPC_ASSERT(lbl, clk, rst, prop)
`define PPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* src/ppc_pkg.sv */
`default_nettype none
package ppc_pkg;
   localparam int NATTR      = 9;
   localparam int ATTR_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_VERTS  = 64;
   localparam int STOP_COUNT = 2;
   localparam int COUNT_W    = 7;
   localparam int LIVE_W     = 8;
   localparam int T_W        = FRAC_BITS + 1;
   localparam int NUM_W      = 33;
   localparam int DEN_W      = 34;
   localparam int IDX_X      = 0;
   localparam int IDX_Y      = 1;
   localparam int IDX_W      = 5;

   typedef logic [NATTR-1:0][ATTR_W-1:0] vec_type;

   typedef enum logic [1:0] {
      PLANE_W       = 2'd0,
      PLANE_W_PLUS_X  = 2'd1,
      PLANE_W_MINUS_X = 2'd2,
      PLANE_W_PLUS_Y  = 2'd3
   } plane_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_EDGE,
      ST_DISPATCH,
      ST_DIV,
      ST_LERP,
      ST_PUSH,
      ST_NEXT,
      ST_FINAL
   } state_type;

   // Signed distance of a vertex to the selected plane, exact in 33 bits.
   function automatic logic signed [NUM_W-1:0] plane_dist(vec_type v, logic [1:0] sel);
      logic signed [NUM_W-1:0] w;
      logic signed [NUM_W-1:0] x;
      logic signed [NUM_W-1:0] y;
      logic signed [NUM_W-1:0] d;
      w = NUM_W'($signed(v[IDX_W]));
      x = NUM_W'($signed(v[IDX_X]));
      y = NUM_W'($signed(v[IDX_Y]));
      case (plane_type'(sel))
         PLANE_W:         d = w;
         PLANE_W_PLUS_X:  d = w + x;
         PLANE_W_MINUS_X: d = w - x;
         PLANE_W_PLUS_Y:  d = w + y;
         default:         d = w;
      endcase
      return d;
   endfunction
endpackage
`default_nettype wire

/* src/ppc_div.sv */
`default_nettype none
// Restoring divider: one quotient bit per cycle, integer bit first.
module ppc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ppc_pkg::NUM_W-1:0]   num,
   input  wire logic [ppc_pkg::DEN_W-1:0]   den,
   output logic                             done,
   output logic [ppc_pkg::T_W-1:0]          quot
);
   localparam int CNT_W = $clog2(ppc_pkg::T_W);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ppc_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [ppc_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [ppc_pkg::T_W-1:0]     quot_ff, quot_in;
   logic [ppc_pkg::DEN_W:0]     trial;
   logic [ppc_pkg::DEN_W:0]     diff;
   logic                        ge;

   always_comb begin
      trial = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = ppc_pkg::DEN_W'(num);
         den_in  = den;
         quot_in = '0;
      end else if (run_ff) begin
         rem_in  = ge ? diff[ppc_pkg::DEN_W-1:0] : trial[ppc_pkg::DEN_W-1:0];
         quot_in = {quot_ff[ppc_pkg::T_W-2:0], ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ppc_pkg::T_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

/* src/ppc_lerp.sv */
`default_nettype none
// One multiplier shared over the nine attributes: a multiply cycle, then a
// round, add and saturate cycle for each attribute.
module ppc_lerp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [ppc_pkg::T_W-1:0]  t,
   input  wire ppc_pkg::vec_type         vec_o,
   input  wire ppc_pkg::vec_type         vec_i,
   output logic                          done,
   output ppc_pkg::vec_type              result
);
   localparam int IDXW  = $clog2(ppc_pkg::NATTR);
   localparam int PROD_W = ppc_pkg::NUM_W + ppc_pkg::T_W + 1;
   localparam int Q_W   = PROD_W - ppc_pkg::FRAC_BITS;
   localparam int R_W   = Q_W + 1;

   logic                        run_ff, run_in;
   logic                        add_ff, add_in;
   logic                        done_ff, done_in;
   logic [IDXW-1:0]             idx_ff, idx_in;
   logic [ppc_pkg::T_W-1:0]     t_ff, t_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   ppc_pkg::vec_type            res_ff, res_in;
   logic signed [ppc_pkg::NUM_W-1:0] dlt;
   logic signed [PROD_W-1:0]    rounded;
   logic signed [Q_W-1:0]       q;
   logic signed [R_W-1:0]       r;
   logic [ppc_pkg::ATTR_W-1:0]  sat;

   always_comb begin
      dlt = ppc_pkg::NUM_W'($signed(vec_i[idx_ff])) - ppc_pkg::NUM_W'($signed(vec_o[idx_ff]));
      prod_in = PROD_W'(dlt * $signed({1'b0, t_ff}));
      rounded = prod_ff + PROD_W'(1 << (ppc_pkg::FRAC_BITS - 1));
      q = rounded[PROD_W-1:ppc_pkg::FRAC_BITS];
      r = R_W'($signed(vec_o[idx_ff])) + R_W'(q);
      if (r > R_W'(32'sh7FFFFFFF)) begin
         sat = 32'h7FFFFFFF;
      end else if (r < -R_W'(33'sh080000000)) begin
         sat = 32'h80000000;
      end else begin
         sat = r[ppc_pkg::ATTR_W-1:0];
      end
   end

   always_comb begin
      run_in  = run_ff;
      add_in  = add_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      t_in    = t_ff;
      res_in  = res_ff;
      if (start) begin
         run_in = 1'b1;
         add_in = 1'b0;
         idx_in = '0;
         t_in   = t;
      end else if (run_ff) begin
         add_in = !add_ff;
         if (add_ff) begin
            res_in[idx_ff] = sat;
            if (idx_ff == IDXW'(ppc_pkg::NATTR - 1)) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff + IDXW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         add_ff  <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         add_ff  <= add_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      t_ff    <= t_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

/* src/polygon_plane_clipper.sv */
// Clips a streamed polygon against one homogeneous plane.
// A first vertex runs no edge; each later vertex runs the edge from the previous one. A crossing
// edge runs the divider, the interpolation and a push; an edge that keeps its end vertex pushes it.
// The last item of a polygon also runs the closing edge and the final item.
// A full output register stalls each push and the final item until rsp_tready drains it.
// Reset is synchronous and active high; it clears all control state and the plane select.
`default_nettype none
`include "polygon_plane_clipper_defines.svh"
module polygon_plane_clipper (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // attr_x, attr_y, attr_c, attr_d, attr_e, attr_w, attr_g, attr_h, attr_i,
   // vertex_count, zero pad
   input  wire logic [295:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // out_x, out_y, out_c, out_d, out_e, out_w, out_g, out_h, out_i
   output logic [287:0]       rsp_tdata,
   // vertex_valid
   output logic               rsp_tuser,
   // polygon_end
   output logic               rsp_tlast,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_wdata
);
   localparam int VB = ppc_pkg::NATTR * ppc_pkg::ATTR_W;

   ppc_pkg::state_type state_ff, state_in;
   logic [1:0]                   plane_ff, plane_in;
   ppc_pkg::vec_type             cur_ff, cur_in;
   ppc_pkg::vec_type             prev_ff, prev_in;
   ppc_pkg::vec_type             first_ff, first_in;
   ppc_pkg::vec_type             held_ff, held_in;
   logic                         held_valid_ff, held_valid_in;
   logic [ppc_pkg::LIVE_W-1:0]   live_ff, live_in;
   logic [ppc_pkg::COUNT_W-1:0]  items_ff, items_in;
   logic [ppc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         last_ff, last_in;
   logic                         stopped_ff, stopped_in;
   logic                         phase_ff, phase_in;
   logic                         edge_ff, edge_in;
   logic                         cross_ff, cross_in;
   logic                         pushb_ff, pushb_in;
   logic                         swap_ff, swap_in;
   logic                         push_lerp_ff, push_lerp_in;
   logic [ppc_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [ppc_pkg::DEN_W-1:0]    den_ff, den_in;
   ppc_pkg::vec_type             out_ff, out_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_user_ff, rsp_user_in;
   logic                         rsp_last_ff, rsp_last_in;

   ppc_pkg::vec_type             vec_a, vec_b, vec_o, vec_i, push_src, lerp_res;
   logic signed [ppc_pkg::NUM_W-1:0] da, db, d_out, d_in;
   logic signed [ppc_pkg::DEN_W:0]   den_full;
   logic                         a_ok, b_ok;
   logic                         div_start, div_done, lerp_start, lerp_done;
   logic [ppc_pkg::T_W-1:0]      t_q;
   logic [ppc_pkg::COUNT_W-1:0]  raw_count, clamp_count;
   logic                         stop_now;
   logic                         push_ok;

   // Edge ends: a is the previous vertex; b is the current one, or the first on the
   // closing edge (previous equals current there).
   assign vec_a = prev_ff;
   assign vec_b = phase_ff ? first_ff : cur_ff;
   assign vec_o = swap_ff ? vec_b : vec_a;
   assign vec_i = swap_ff ? vec_a : vec_b;
   assign push_src = push_lerp_ff ? lerp_res : vec_b;

   always_comb begin
      da = ppc_pkg::plane_dist(vec_a, plane_ff);
      db = ppc_pkg::plane_dist(vec_b, plane_ff);
      a_ok = !da[ppc_pkg::NUM_W-1];
      b_ok = !db[ppc_pkg::NUM_W-1];
      d_out = b_ok ? da : db;
      d_in  = b_ok ? db : da;
      den_full = (ppc_pkg::DEN_W+1)'(d_in) - (ppc_pkg::DEN_W+1)'(d_out);
      raw_count = req_tdata[VB +: ppc_pkg::COUNT_W];
      if (raw_count == '0) begin
         clamp_count = ppc_pkg::COUNT_W'(1);
      end else if (raw_count > ppc_pkg::COUNT_W'(ppc_pkg::MAX_VERTS)) begin
         clamp_count = ppc_pkg::COUNT_W'(ppc_pkg::MAX_VERTS);
      end else begin
         clamp_count = raw_count;
      end
      stop_now = stopped_ff || (edge_ff && (live_ff < ppc_pkg::LIVE_W'(ppc_pkg::STOP_COUNT)));
      push_ok = !(held_valid_ff && rsp_valid_ff);
   end

   assign div_start  = (state_ff == ppc_pkg::ST_DISPATCH) && cross_ff;
   assign lerp_start = (state_ff == ppc_pkg::ST_DIV) && div_done;

   ppc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (t_q)
   );

   ppc_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .t      (t_q),
      .vec_o  (vec_o),
      .vec_i  (vec_i),
      .done   (lerp_done),
      .result (lerp_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ppc_pkg::ST_START;
         end
         ppc_pkg::ST_START: begin
            if (items_ff == '0) state_in = ppc_pkg::ST_NEXT;
            else if (stopped_ff) state_in = ppc_pkg::ST_DISPATCH;
            else state_in = ppc_pkg::ST_EDGE;
         end
         ppc_pkg::ST_EDGE: state_in = ppc_pkg::ST_DISPATCH;
         ppc_pkg::ST_DISPATCH: begin
            if (cross_ff) state_in = ppc_pkg::ST_DIV;
            else if (pushb_ff) state_in = ppc_pkg::ST_PUSH;
            else if (phase_ff) state_in = ppc_pkg::ST_FINAL;
            else state_in = ppc_pkg::ST_NEXT;
         end
         ppc_pkg::ST_DIV: begin
            if (div_done) state_in = ppc_pkg::ST_LERP;
         end
         ppc_pkg::ST_LERP: begin
            if (lerp_done) state_in = ppc_pkg::ST_PUSH;
         end
         ppc_pkg::ST_PUSH: begin
            if (push_ok) state_in = ppc_pkg::ST_DISPATCH;
         end
         ppc_pkg::ST_NEXT: begin
            if (!last_ff) state_in = ppc_pkg::ST_IDLE;
            else if (stop_now) state_in = ppc_pkg::ST_DISPATCH;
            else state_in = ppc_pkg::ST_EDGE;
         end
         ppc_pkg::ST_FINAL: begin
            if (!rsp_valid_ff) state_in = ppc_pkg::ST_IDLE;
         end
         default: state_in = ppc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and control registers.
   always_comb begin
      plane_in      = csr_we ? csr_wdata : plane_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      live_in       = live_ff;
      items_in      = items_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      stopped_in    = stopped_ff;
      phase_in      = phase_ff;
      edge_in       = edge_ff;
      cross_in      = cross_ff;
      pushb_in      = pushb_ff;
      swap_in       = swap_ff;
      push_lerp_in  = push_lerp_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cur_in   = req_tdata[VB-1:0];
               count_in = clamp_count;
               last_in  = ({1'b0, items_ff} + (ppc_pkg::COUNT_W+1)'(1))
                          >= {1'b0, clamp_count};
               phase_in = 1'b0;
               edge_in  = 1'b0;
            end
         end
         ppc_pkg::ST_START: begin
            if (items_ff == '0) begin
               first_in      = cur_ff;
               live_in       = ppc_pkg::LIVE_W'(count_ff);
               stopped_in    = 1'b0;
               held_valid_in = 1'b0;
            end else if (stopped_ff) begin
               pushb_in = 1'b1;
               cross_in = 1'b0;
            end
         end
         ppc_pkg::ST_EDGE: begin
            cross_in = a_ok ^ b_ok;
            pushb_in = b_ok;
            swap_in  = !b_ok;
            num_in   = ppc_pkg::NUM_W'(-d_out);
            den_in   = den_full[ppc_pkg::DEN_W-1:0];
            edge_in  = !phase_ff;
            if (b_ok && !a_ok) begin
               live_in = live_ff + ppc_pkg::LIVE_W'(1);
            end else if (!b_ok && !a_ok && (live_ff != '0)) begin
               live_in = live_ff - ppc_pkg::LIVE_W'(1);
            end
         end
         ppc_pkg::ST_DISPATCH: begin
            if (cross_ff) begin
               cross_in     = 1'b0;
               push_lerp_in = 1'b1;
            end else if (pushb_ff) begin
               pushb_in     = 1'b0;
               push_lerp_in = 1'b0;
            end
         end
         ppc_pkg::ST_PUSH: begin
            if (push_ok) begin
               if (held_valid_ff) begin
                  out_in       = held_ff;
                  rsp_valid_in = 1'b1;
                  rsp_user_in  = 1'b1;
                  rsp_last_in  = 1'b0;
               end
               held_in       = push_src;
               held_valid_in = 1'b1;
            end
         end
         ppc_pkg::ST_NEXT: begin
            stopped_in = stop_now;
            prev_in    = cur_ff;
            edge_in    = 1'b0;
            if (last_ff) begin
               phase_in = 1'b1;
               if (stop_now) begin
                  pushb_in = 1'b1;
                  cross_in = 1'b0;
               end
            end else begin
               items_in = items_ff + ppc_pkg::COUNT_W'(1);
            end
         end
         ppc_pkg::ST_FINAL: begin
            if (!rsp_valid_ff) begin
               // A polygon that lost every vertex still closes with one empty item.
               out_in        = held_valid_ff ? held_ff : '0;
               rsp_valid_in  = 1'b1;
               rsp_user_in   = held_valid_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               live_in       = '0;
               items_in      = '0;
               stopped_in    = 1'b0;
               phase_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppc_pkg::ST_IDLE;
         plane_ff      <= 2'd0;
         held_valid_ff <= 1'b0;
         live_ff       <= '0;
         items_ff      <= '0;
         count_ff      <= '0;
         last_ff       <= 1'b0;
         stopped_ff    <= 1'b0;
         phase_ff      <= 1'b0;
         edge_ff       <= 1'b0;
         cross_ff      <= 1'b0;
         pushb_ff      <= 1'b0;
         swap_ff       <= 1'b0;
         push_lerp_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_user_ff   <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         plane_ff      <= plane_in;
         held_valid_ff <= held_valid_in;
         live_ff       <= live_in;
         items_ff      <= items_in;
         count_ff      <= count_in;
         last_ff       <= last_in;
         stopped_ff    <= stopped_in;
         phase_ff      <= phase_in;
         edge_ff       <= edge_in;
         cross_ff      <= cross_in;
         pushb_ff      <= pushb_in;
         swap_ff       <= swap_in;
         push_lerp_ff  <= push_lerp_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_user_ff   <= rsp_user_in;
         rsp_last_ff   <= rsp_last_in;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      first_ff <= first_in;
      held_ff  <= held_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      out_ff   <= out_in;
   end

   assign req_tready = (state_ff == ppc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PPC_ASSERT(a_empty_only_at_end, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tlast)
   `PPC_ASSERT(a_div_done_in_div, clock, reset, div_done |-> state_ff == ppc_pkg::ST_DIV)
   `PPC_ASSERT(a_idle_between_polys, clock, reset, state_ff == ppc_pkg::ST_IDLE && items_ff == '0 |-> live_ff == '0 && !held_valid_ff)
   `PPC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ppc_pkg::ST_IDLE && !rsp_tvalid)
endmodule
`default_nettype wire
